### src/ssc_pkg.sv
package ssc_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int SINE_FRAC_DEF  = 30;

    localparam int CORDIC_ITERS = 31;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int CW           = 34;   // cordic datapath width
    localparam int PROD_W       = 50;   // angle times binary-angle scale

    localparam logic signed [30:0] MDEG_TO_BA = 31'sd781874935;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30   = 34'sd1073741824;

    localparam int NUM_W  = 42;         // |dsine * 1024|
    localparam int DEN_W  = 16;         // |wrapped code difference|
    localparam int SLOPE_W = 43;
    localparam int ICPT_W  = 48;
    localparam int ACC_W   = 61;
    localparam int CODE_W  = 16;

    // arctan(2^-i) in 32-bit binary-angle units, held in 30 bits
    function automatic logic [29:0] atan_ba(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'h20000000;
            5'd1:  r = 30'h12E4051E;
            5'd2:  r = 30'h09FB385B;
            5'd3:  r = 30'h051111D4;
            5'd4:  r = 30'h028B0D43;
            5'd5:  r = 30'h0145D7E1;
            5'd6:  r = 30'h00A2F61E;
            5'd7:  r = 30'h00517C55;
            5'd8:  r = 30'h0028BE53;
            5'd9:  r = 30'h00145F2F;
            5'd10: r = 30'h000A2F98;
            5'd11: r = 30'h000517CC;
            5'd12: r = 30'h00028BE6;
            5'd13: r = 30'h000145F3;
            5'd14: r = 30'h0000A2FA;
            5'd15: r = 30'h0000517D;
            5'd16: r = 30'h000028BE;
            5'd17: r = 30'h0000145F;
            5'd18: r = 30'h00000A30;
            5'd19: r = 30'h00000518;
            5'd20: r = 30'h0000028C;
            5'd21: r = 30'h00000146;
            5'd22: r = 30'h000000A3;
            5'd23: r = 30'h00000051;
            5'd24: r = 30'h00000029;
            5'd25: r = 30'h00000014;
            5'd26: r = 30'h0000000A;
            5'd27: r = 30'h00000005;
            5'd28: r = 30'h00000003;
            5'd29: r = 30'h00000001;
            5'd30: r = 30'h00000001;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

endpackage

### src/ssc_cordic.sv
module ssc_cordic
    import ssc_pkg::*;
#(
    parameter int SINE_FRAC_BITS = SINE_FRAC_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [18:0] angle_mdeg,
    output logic               done,
    output logic signed [31:0] sine
);

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_MUL  = 5'b00010,
        C_FOLD = 5'b00100,
        C_ITER = 5'b01000,
        C_FIN  = 5'b10000
    } cstate_t;

    localparam logic [CW-1:0] LSB_MASK = CW'((64'd1 << (30 - SINE_FRAC_BITS)) - 64'd1);

    cstate_t                  state_reg, state_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [CW-1:0]     x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [31:0]       sine_reg, sine_next;
    logic                     done_reg, done_next;

    logic signed [PROD_W-1:0] rnd;
    logic [31:0]              ba;
    logic signed [CW-1:0]     z0, zf, shx, shy, at, yc;

    assign done = done_reg;
    assign sine = sine_reg;

    always_comb
    begin
        rnd = prod_reg + PROD_W'(32768);
        ba  = rnd[47:16];
        z0  = {{(CW-32){ba[31]}}, ba};
        // sin(180 - a) = sin(a)
        if (z0 > 34'sh40000000)
            zf = 34'sh80000000 - z0;
        else if (z0 < -34'sh40000000)
            zf = -34'sh80000000 - z0;
        else
            zf = z0;
        shx = x_reg >>> iter_reg;
        shy = y_reg >>> iter_reg;
        at  = {{(CW-30){1'b0}}, atan_ba(iter_reg)};
        if (y_reg > ONE_Q30)
            yc = ONE_Q30;
        else if (y_reg < -ONE_Q30)
            yc = -ONE_Q30;
        else
            yc = y_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        iter_next  = iter_reg;
        sine_next  = sine_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    prod_next  = PROD_W'(angle_mdeg) * PROD_W'(MDEG_TO_BA);
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                z_next     = zf;
                x_next     = CORDIC_X0;
                y_next     = '0;
                iter_next  = '0;
                state_next = C_ITER;
            end
            C_ITER:
            begin
                if (!z_reg[CW-1])
                begin
                    x_next = x_reg - shy;
                    y_next = y_reg + shx;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + shy;
                    y_next = y_reg - shx;
                    z_next = z_reg + at;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
                    state_next = C_FOLD;
            end
            C_FOLD:
            begin
                state_next = C_FIN;
            end
            C_FIN:
            begin
                sine_next  = 32'(yc & ~LSB_MASK);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        iter_reg <= iter_next;
        sine_reg <= sine_next;
    end

endmodule

### src/ssc_divider.sv
module ssc_divider
    import ssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next, done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next, den_reg, den_next;
    logic [DEN_W:0]   trial;

    assign done = done_reg;
    assign quo  = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, q_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // q_reg shifts the dividend out and quotient bits in
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

### src/ssc_mulsub.sv
module ssc_mulsub
    import ssc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ACC_W-1:0]   base,
    input  logic signed [SLOPE_W-1:0] slope,
    input  logic [CODE_W-1:0]         code,
    output logic                      done,
    output logic signed [ACC_W-1:0]   acc
);

    localparam int CNT_W = $clog2(CODE_W);

    logic                    busy_reg, busy_next, done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next, m_reg, m_next;
    logic [CODE_W-1:0]       b_reg, b_next;

    assign done = done_reg;
    assign acc  = acc_reg;

    // acc = base - slope * code, one code bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        m_next    = m_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = base;
            m_next    = ACC_W'(slope);
            b_next    = code;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg - m_reg;
            m_next   = m_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CODE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        m_reg   <= m_next;
        b_reg   <= b_next;
    end

endmodule

### src/sine_segment_calibration_fit_core.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   angle_mdeg, adc_code, first_point
// result    out        out_valid / out_ready slope_q40, intercept_q30, segment_number,
//                                            zero_span
// A point that starts a table only runs the CORDIC, one rotation per cycle.
// A segment point runs the sine, then the bit-serial divider, then the
// shift-subtract multiplier, plus sequencing.
// A zero span skips divide and multiply; an ignored point (table full) is dropped before the sine.
// in_ready is high only while the sequencer is idle. A finished result waits in the
// output register; the next point is accepted meanwhile and stalls only at its end.
// rst_n clears the held point and segment count asynchronously.
module sine_segment_calibration_fit_core
    import ssc_pkg::*;
#(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int SINE_FRAC_BITS = SINE_FRAC_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [18:0]        angle_mdeg,
    input  logic [15:0]               adc_code,
    input  logic                      first_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SLOPE_W-1:0] slope_q40,
    output logic signed [ICPT_W-1:0]  intercept_q30,
    output logic [4:0]                segment_number,
    output logic                      zero_span
);

    localparam int CLG   = $clog2(MAX_POINTS);
    localparam int SEG_W = (CLG > 5) ? CLG : 5;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_SINE = 7'b0000100,
        S_PREP = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [18:0]        angle_reg, angle_next;
    logic [CODE_W-1:0]         code_reg, code_next;
    logic                      first_reg, first_next;
    logic                      store_reg, store_next;
    logic signed [31:0]        sine_reg, sine_next;
    logic signed [31:0]        prev_sine_reg, prev_sine_next;
    logic [CODE_W-1:0]         prev_code_reg, prev_code_next;
    logic                      have_prev_reg, have_prev_next;
    logic [SEG_W-1:0]          seg_count_reg, seg_count_next;
    logic                      neg_reg, neg_next;
    logic                      zero_reg, zero_next;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;
    logic signed [ICPT_W-1:0]  icpt_reg, icpt_next;
    logic                      ovalid_reg, ovalid_next;
    logic signed [SLOPE_W-1:0] oslope_reg, oslope_next;
    logic signed [ICPT_W-1:0]  oicpt_reg, oicpt_next;
    logic [4:0]                oseg_reg, oseg_next;
    logic                      ozero_reg, ozero_next;

    logic                      cordic_start, cordic_done;
    logic signed [31:0]        cordic_sine;
    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_num, div_quo;
    logic [DEN_W-1:0]          div_den;
    logic                      mul_start, mul_done;
    logic signed [ACC_W-1:0]   mul_base, mul_acc;

    logic signed [32:0]        dsine;
    logic signed [SLOPE_W-1:0] num_s, num_abs;
    logic signed [DEN_W-1:0]   d;
    logic signed [DEN_W:0]     d_abs;
    logic signed [SLOPE_W-1:0] quo_s;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = ovalid_reg;
    assign slope_q40      = oslope_reg;
    assign intercept_q30  = oicpt_reg;
    assign segment_number = oseg_reg;
    assign zero_span      = ozero_reg;

    ssc_cordic #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cordic_start),
        .angle_mdeg (angle_reg),
        .done       (cordic_done),
        .sine       (cordic_sine)
    );

    ssc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    ssc_mulsub u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .base  (mul_base),
        .slope (slope_next),
        .code  (prev_code_reg),
        .done  (mul_done),
        .acc   (mul_acc)
    );

    always_comb
    begin
        dsine   = 33'(sine_reg) - 33'(prev_sine_reg);
        num_s   = {dsine, 10'b0};
        num_abs = num_s[SLOPE_W-1] ? -num_s : num_s;
        d       = DEN_W'(code_reg - prev_code_reg);
        d_abs   = d[DEN_W-1] ? -(DEN_W+1)'(d) : (DEN_W+1)'(d);
        div_num = num_abs[NUM_W-1:0];
        div_den = d_abs[DEN_W-1:0];
        quo_s   = neg_reg ? -SLOPE_W'(div_quo) : SLOPE_W'(div_quo);
        mul_base = ACC_W'(signed'({prev_sine_reg, 10'b0}));
    end

    always_comb
    begin
        state_next     = state_reg;
        angle_next     = angle_reg;
        code_next      = code_reg;
        first_next     = first_reg;
        store_next     = store_reg;
        sine_next      = sine_reg;
        prev_sine_next = prev_sine_reg;
        prev_code_next = prev_code_reg;
        have_prev_next = have_prev_reg;
        seg_count_next = seg_count_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        slope_next     = slope_reg;
        icpt_next      = icpt_reg;
        ovalid_next    = ovalid_reg;
        oslope_next    = oslope_reg;
        oicpt_next     = oicpt_reg;
        oseg_next      = oseg_reg;
        ozero_next     = ozero_reg;
        cordic_start   = 1'b0;
        div_start      = 1'b0;
        mul_start      = 1'b0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    angle_next = angle_mdeg;
                    code_next  = adc_code;
                    first_next = first_point;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (first_reg || !have_prev_reg)
                begin
                    store_next   = 1'b1;
                    cordic_start = 1'b1;
                    state_next   = S_SINE;
                end
                else if (seg_count_reg >= SEG_W'(MAX_POINTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    store_next   = 1'b0;
                    cordic_start = 1'b1;
                    state_next   = S_SINE;
                end
            end
            S_SINE:
            begin
                if (cordic_done)
                begin
                    if (store_reg)
                    begin
                        prev_sine_next = cordic_sine;
                        prev_code_next = code_reg;
                        have_prev_next = 1'b1;
                        seg_count_next = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        sine_next  = cordic_sine;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                if (d == '0)
                begin
                    zero_next  = 1'b1;
                    slope_next = '0;
                    icpt_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    zero_next  = 1'b0;
                    neg_next   = num_s[SLOPE_W-1] ^ d[DEN_W-1];
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    slope_next = quo_s;
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    icpt_next  = mul_acc[ICPT_W+9:10];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold here while the previous result is still unclaimed
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next    = 1'b1;
                    oslope_next    = slope_reg;
                    oicpt_next     = icpt_reg;
                    oseg_next      = seg_count_reg[4:0];
                    ozero_next     = zero_reg;
                    prev_sine_next = sine_reg;
                    prev_code_next = code_reg;
                    seg_count_next = seg_count_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_sine_reg <= '0;
            prev_code_reg <= '0;
            have_prev_reg <= 1'b0;
            seg_count_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_sine_reg <= prev_sine_next;
            prev_code_reg <= prev_code_next;
            have_prev_reg <= have_prev_next;
            seg_count_reg <= seg_count_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg  <= angle_next;
        code_reg   <= code_next;
        first_reg  <= first_next;
        store_reg  <= store_next;
        sine_reg   <= sine_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        oslope_reg <= oslope_next;
        oicpt_reg  <= oicpt_next;
        oseg_reg   <= oseg_next;
        ozero_reg  <= ozero_next;
    end

endmodule

### src/ssc_checker.sv
module ssc_checker
    import ssc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [SLOPE_W-1:0] slope_q40,
    input logic signed [ICPT_W-1:0]  intercept_q30,
    input logic [4:0]                segment_number,
    input logic                      zero_span
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slope_q40)
            && $stable(intercept_q30) && $stable(segment_number) && $stable(zero_span))
        else $error("result changed while stalled");

    // a zero span carries zero slope and intercept
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_span |-> slope_q40 == '0 && intercept_q30 == '0)
        else $error("zero span with nonzero fit");

    // each accepted point keeps the sequencer busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a point was taken");

    // a new result shows up only as the sequencer goes idle
    a_new_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while sequencer busy");

endmodule

bind sine_segment_calibration_fit_core ssc_checker u_ssc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .slope_q40      (slope_q40),
    .intercept_q30  (intercept_q30),
    .segment_number (segment_number),
    .zero_span      (zero_span)
);

### verif/tb_top.sv
module tb_top;
    import ssc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC_BITS   = SINE_FRAC_DEF;
    localparam int  TABLE_PTS   = MAX_POINTS_DEF;
    localparam int  NUM_RANDOM  = 900;
    localparam longint CYCLE_LIMIT = 2000000;

    localparam longint ATAN_TBL [CORDIC_ITERS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001
    };

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
        logic [4:0]                seg;
        logic                      zero;
    } segment_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [18:0]        angle_mdeg = '0;
    logic [15:0]               adc_code = '0;
    logic                      first_point = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [SLOPE_W-1:0] slope_q40;
    logic signed [ICPT_W-1:0]  intercept_q30;
    logic [4:0]                segment_number;
    logic                      zero_span;

    // predictor state
    longint   held_sine = 0;
    bit [15:0] held_code = '0;
    bit       held_valid = 1'b0;
    int       seg_cnt = 0;

    segment_t expected_segs[$];
    int       error_count = 0;
    int       segs_seen = 0;
    int       zero_seen = 0;
    int       points_sent = 0;
    longint   cycle_count = 0;
    int       burst_left = 0;

    sine_segment_calibration_fit_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .angle_mdeg(angle_mdeg), .adc_code(adc_code), .first_point(first_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .slope_q40(slope_q40), .intercept_q30(intercept_q30),
        .segment_number(segment_number), .zero_span(zero_span)
    );

    always #5 clk = ~clk;

    function automatic longint sine_q30(longint mdeg);
        longint p, z, x, y, nx;
        bit [31:0] ba;
        int i;
        p = mdeg * 64'sd781874935 + 64'sd32768;
        ba = p[47:16];
        z = longint'(ba);
        if (ba[31])
            z = z - 64'sh100000000;
        if (z > 64'sh40000000)
            z = 64'sh80000000 - z;
        else if (z < -64'sh40000000)
            z = -64'sh80000000 - z;
        x = 652032874;
        y = 0;
        for (i = 0; i < CORDIC_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TBL[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TBL[i];
            end
            x = nx;
        end
        if (y > 64'sd1073741824)
            y = 64'sd1073741824;
        if (y < -64'sd1073741824)
            y = -64'sd1073741824;
        return (y >>> (30 - FRAC_BITS)) <<< (30 - FRAC_BITS);
    endfunction

    // advance predictor by one point, queue a segment if one is due
    function automatic void predict_segment(logic signed [18:0] ang, logic [15:0] code,
                                            logic first);
        longint s, d, slope, icpt;
        bit [15:0] diff;
        segment_t seg;
        if (first || !held_valid)
        begin
            held_sine  = sine_q30(longint'(ang));
            held_code  = code;
            held_valid = 1'b1;
            seg_cnt    = 0;
            return;
        end
        if (seg_cnt >= TABLE_PTS - 1)
            return;
        s = sine_q30(longint'(ang));
        diff = code - held_code;
        d = longint'(signed'(diff));
        slope = 0;
        icpt = 0;
        seg.zero = (d == 0);
        if (d != 0)
        begin
            slope = ((s - held_sine) * 1024) / d;
            icpt  = (held_sine * 1024 - slope * longint'(held_code)) >>> 10;
        end
        seg.slope = slope[SLOPE_W-1:0];
        seg.icpt  = icpt[ICPT_W-1:0];
        seg.seg   = seg_cnt[4:0];
        expected_segs.push_back(seg);
        held_sine = s;
        held_code = code;
        seg_cnt++;
    endfunction

    // one point; valid stays high into the next call unless a gap lowers it
    task automatic send_point(logic signed [18:0] ang, logic [15:0] code, logic first);
        if (burst_left == 0)
        begin
            int gap;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        angle_mdeg  <= ang;
        adc_code    <= code;
        first_point <= first;
        do
            @(posedge clk);
        while (!in_ready);
        predict_segment(ang, code, first);
        points_sent++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $realtime);
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver: stall pattern steps through four modes picked from the cycle counter
    always @(posedge clk)
    begin
        case (cycle_count[9:7] % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= $urandom_range(0, 7) == 0;
            default: out_ready <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        segment_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_segs.size() == 0)
            begin
                $display("%0t unexpected segment transaction slope=%0d", $realtime, slope_q40);
                error_count++;
            end
            else
            begin
                e = expected_segs.pop_front();
                segs_seen++;
                if (e.zero)
                    zero_seen++;
                if (slope_q40 !== e.slope)
                begin
                    $display("%0t slope exp=%0d got=%0d", $realtime, e.slope, slope_q40);
                    error_count++;
                end
                if (intercept_q30 !== e.icpt)
                begin
                    $display("%0t intercept exp=%0d got=%0d", $realtime, e.icpt,
                             intercept_q30);
                    error_count++;
                end
                if (segment_number !== e.seg)
                begin
                    $display("%0t segment exp=%0d got=%0d", $realtime, e.seg,
                             segment_number);
                    error_count++;
                end
                if (zero_span !== e.zero)
                begin
                    $display("%0t zero_span exp=%0b got=%0b", $realtime, e.zero, zero_span);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        // no held point after reset: taken as a table start
        send_point(19'sd30000, 16'd1000, 1'b0);
        send_point(19'sd90000, 16'd2000, 1'b0);
        send_point(19'sd180000, 16'd0, 1'b0);
        send_point(-19'sd180000, 16'd65535, 1'b0);
        send_point(-19'sd90000, 16'd65535, 1'b0);   // zero span
        send_point(19'sd0, 16'd0, 1'b0);            // diff wraps to +1
        send_point(19'sd45000, 16'd32768, 1'b0);    // diff -32768
        send_point(19'sh40000, 16'd12345, 1'b1);    // most negative angle
        send_point(19'sd262143, 16'd12346, 1'b0);   // out of range angles
        send_point(19'sd200000, 16'd65535, 1'b0);
        send_point(-19'sd200000, 16'd0, 1'b0);
        send_point(19'sd89999, 16'd40000, 1'b0);
        send_point(19'sd90001, 16'd40001, 1'b0);
        send_point(-19'sd1, 16'd40001, 1'b0);
    endtask

    task automatic test_table_full();
        int i;
        send_point(19'sd0, 16'd100, 1'b1);
        for (i = 0; i < TABLE_PTS + 3; i++)
            send_point(19'($urandom_range(0, 360000)) - 19'sd180000,
                       16'(100 + 37 * (i + 1)), 1'b0);
    endtask

    task automatic test_random_tables();
        int len, j;
        logic [15:0] code;
        while (points_sent < NUM_RANDOM)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: fully random fields
                send_point(19'($urandom), 16'($urandom), 1'($urandom));
                continue;
            end
            len = $urandom_range(0, 5) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 10);
            code = 16'($urandom);
            send_point(19'($urandom_range(0, 360000)) - 19'sd180000, code, 1'b1);
            for (j = 0; j < len; j++)
            begin
                case ($urandom_range(0, 7))
                    0: code = code;                           // zero span
                    1: code = 16'($urandom);
                    default: code = code + 16'($urandom_range(1, 3000));
                endcase
                if ($urandom_range(0, 15) == 0)
                    send_point(19'($urandom), code, 1'b0);
                else
                    send_point(19'($urandom_range(0, 360000)) - 19'sd180000, code, 1'b0);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random_tables();
        in_valid <= 1'b0;
        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("tb_top: %0d points sent, %0d segments checked, %0d zero span",
                 points_sent, segs_seen, zero_seen);
        $display("tb_top: covered reset start, wraps, table full and random tables");
        if (error_count == 0 && expected_segs.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### filelist.f
src/ssc_pkg.sv
src/ssc_cordic.sv
src/ssc_divider.sv
src/ssc_mulsub.sv
src/sine_segment_calibration_fit_core.sv
src/ssc_checker.sv
verif/tb_top.sv
